>>> src/mrtu_pkg.sv
`timescale 1ns / 1ps
package mrtu_pkg;

  // Command classes handed from the front end to the byte sequencer
  typedef enum logic [1:0] {
    OP_READ      = 2'd0,  // read request: eight bytes incl. CRC
    OP_WRITE_HDR = 2'd1,  // write header: seven bytes, plus CRC when empty
    OP_DATA      = 2'd2,  // payload byte of an open write
    OP_DATA_LAST = 2'd3   // final payload byte, followed by the CRC
  } op_t;

  // One queued command
  typedef struct packed {
    op_t         op;
    logic [15:0] addr;  // start address (headers)
    logic [15:0] arg;   // register count, or byte count / data byte in [7:0]
  } cmd_t;

  localparam logic [15:0] CRC_PRESET = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;

endpackage

>>> src/mrtu_front.sv
`timescale 1ns / 1ps
module mrtu_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_push,
  input  logic          in_full,
  input  logic [1:0]    in_kind,
  input  logic [15:0]   in_start_address,
  input  logic [15:0]   in_register_count,
  input  logic [7:0]    in_byte_count,
  input  logic [7:0]    in_data_byte,
  output logic          q_push,
  output mrtu_pkg::cmd_t q_cmd
);
  import mrtu_pkg::*;

  localparam logic [1:0] KIND_READ      = 2'd0;
  localparam logic [1:0] KIND_WRITE_HDR = 2'd1;
  localparam logic [1:0] KIND_DATA      = 2'd2;

  logic       write_open_r, write_open_nxt;
  logic [7:0] left_r, left_nxt;
  logic       accept;

  assign accept = in_push && !in_full;

  // Classify the transaction and track the open write
  always_comb begin
    write_open_nxt = write_open_r;
    left_nxt       = left_r;
    q_push         = 1'b0;
    q_cmd.op       = OP_READ;
    q_cmd.addr     = in_start_address;
    q_cmd.arg      = in_register_count;
    if (accept) begin
      priority case (in_kind)
        KIND_READ: begin
          q_push         = 1'b1;
          write_open_nxt = 1'b0;
          left_nxt       = 8'd0;
        end
        KIND_WRITE_HDR: begin
          q_push         = 1'b1;
          q_cmd.op       = OP_WRITE_HDR;
          q_cmd.arg      = {8'd0, in_byte_count};
          write_open_nxt = (in_byte_count != 8'd0);
          left_nxt       = in_byte_count;
        end
        KIND_DATA: begin
          // stray data bytes are dropped
          if (write_open_r) begin
            q_push         = 1'b1;
            q_cmd.op       = (left_r == 8'd1) ? OP_DATA_LAST : OP_DATA;
            q_cmd.arg      = {8'd0, in_data_byte};
            left_nxt       = left_r - 8'd1;
            write_open_nxt = (left_r != 8'd1);
          end
        end
        default: begin
          // unused kind: ignored
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_open_r <= 1'b0;
      left_r       <= 8'd0;
    end else begin
      write_open_r <= write_open_nxt;
      left_r       <= left_nxt;
    end
  end

endmodule

>>> src/mrtu_cmd_fifo.sv
`timescale 1ns / 1ps
module mrtu_cmd_fifo #(
  parameter int DEPTH = 4  // power of two, at least 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mrtu_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output mrtu_pkg::cmd_t head_cmd,
  output logic           empty
);
  import mrtu_pkg::*;

  localparam int AW = $clog2(DEPTH);

  cmd_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   count_r, count_nxt;
  logic          do_push, do_pop;

  assign full     = (count_r == (AW + 1)'(DEPTH));
  assign empty    = (count_r == '0);
  assign head_cmd = mem[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (!do_push && do_pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_cmd;
  end

endmodule

>>> src/mrtu_back.sv
`timescale 1ns / 1ps
module mrtu_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [7:0]     slave_id,
  input  mrtu_pkg::cmd_t head_cmd,
  input  logic           q_empty,
  output logic           q_pop,
  output logic           out_empty,
  input  logic           out_pop,
  output logic [7:0]     out_tx_byte,
  output logic           out_frame_end
);
  import mrtu_pkg::*;

  localparam logic [7:0] FN_READ_REGS  = 8'h03;
  localparam logic [7:0] FN_WRITE_REGS = 8'h10;

  // One byte of CRC-16/MODBUS, bit-serial steps unrolled
  function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  logic [3:0]  idx_r, idx_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  tx_byte_r;
  logic        frame_end_r;

  logic        fire;
  logic [15:0] cur_crc;
  logic [7:0]  sel_byte;
  logic        is_crc, is_end, is_last;

  assign fire      = !q_empty && (!out_valid_r || out_pop);
  assign q_pop     = fire && is_last;
  assign out_empty = !out_valid_r;
  assign out_tx_byte   = tx_byte_r;
  assign out_frame_end = frame_end_r;

  // A header starts a fresh CRC; payload bytes continue the running one
  assign cur_crc = ((idx_r == 4'd0) &&
                    (head_cmd.op == OP_READ || head_cmd.op == OP_WRITE_HDR)) ?
                   CRC_PRESET : crc_r;

  // Byte selection per command and position
  always_comb begin
    sel_byte = 8'd0;
    is_crc   = 1'b0;
    is_end   = 1'b0;
    is_last  = 1'b0;
    unique case (head_cmd.op)
      OP_READ: begin
        unique case (idx_r)
          4'd0:    sel_byte = slave_id;
          4'd1:    sel_byte = FN_READ_REGS;
          4'd2:    sel_byte = head_cmd.addr[15:8];
          4'd3:    sel_byte = head_cmd.addr[7:0];
          4'd4:    sel_byte = head_cmd.arg[15:8];
          4'd5:    sel_byte = head_cmd.arg[7:0];
          4'd6: begin
            sel_byte = cur_crc[7:0];
            is_crc   = 1'b1;
          end
          default: begin
            sel_byte = cur_crc[15:8];
            is_crc   = 1'b1;
            is_end   = 1'b1;
            is_last  = 1'b1;
          end
        endcase
      end
      OP_WRITE_HDR: begin
        unique case (idx_r)
          4'd0:    sel_byte = slave_id;
          4'd1:    sel_byte = FN_WRITE_REGS;
          4'd2:    sel_byte = head_cmd.addr[15:8];
          4'd3:    sel_byte = head_cmd.addr[7:0];
          4'd4:    sel_byte = 8'd0;
          4'd5:    sel_byte = {1'b0, head_cmd.arg[7:1]};
          4'd6: begin
            sel_byte = head_cmd.arg[7:0];
            // a non-empty write hands over to its payload here
            is_last  = (head_cmd.arg[7:0] != 8'd0);
          end
          4'd7: begin
            sel_byte = cur_crc[7:0];
            is_crc   = 1'b1;
          end
          default: begin
            sel_byte = cur_crc[15:8];
            is_crc   = 1'b1;
            is_end   = 1'b1;
            is_last  = 1'b1;
          end
        endcase
      end
      OP_DATA: begin
        sel_byte = head_cmd.arg[7:0];
        is_last  = 1'b1;
      end
      OP_DATA_LAST: begin
        unique case (idx_r)
          4'd0:    sel_byte = head_cmd.arg[7:0];
          4'd1: begin
            sel_byte = cur_crc[7:0];
            is_crc   = 1'b1;
          end
          default: begin
            sel_byte = cur_crc[15:8];
            is_crc   = 1'b1;
            is_end   = 1'b1;
            is_last  = 1'b1;
          end
        endcase
      end
      default: begin
        is_last = 1'b1;
      end
    endcase
  end

  // Sequencer, CRC and output register
  always_comb begin
    idx_nxt       = idx_r;
    crc_nxt       = crc_r;
    out_valid_nxt = out_valid_r;
    if (out_pop && out_valid_r) out_valid_nxt = 1'b0;
    if (fire) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = is_last ? 4'd0 : idx_r + 4'd1;
      if (!is_crc) crc_nxt = crc_add(cur_crc, sel_byte);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 4'd0;
      crc_r       <= CRC_PRESET;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      tx_byte_r   <= sel_byte;
      frame_end_r <= is_end;
    end
  end

endmodule

>>> src/modbus_rtu_request_framer_unit.sv
`timescale 1ns / 1ps
// Modbus RTU request framer. Requests are pushed in like a queue and the frame
// bytes are popped out, one transaction per byte, CRC-16/MODBUS low byte first
// with out_frame_end on the last CRC byte. A front end classifies each request
// into a small command queue (QUEUE_DEPTH entries); a byte sequencer drains it
// at one byte per cycle unless the output stalls. A read request is framed as
// 8 bytes, a write header 7 (9 when its byte count is zero), a payload byte 1 and
// the final payload byte 3 (data plus CRC), so payload streams at one byte
// per cycle. Input is taken every cycle while the queue has room. Stray data
// bytes and kind 3 are accepted and dropped. cfg_slave_id may be written at any
// time the block is idle; cfg_ready is always high.
module modbus_rtu_request_framer_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // request side
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_kind,
  input  logic [15:0] in_start_address,
  input  logic [15:0] in_register_count,
  input  logic [7:0]  in_byte_count,
  input  logic [7:0]  in_data_byte,
  // byte side
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_tx_byte,
  output logic        out_frame_end,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_slave_id
);
  import mrtu_pkg::*;

  logic [7:0] slave_id_r;
  logic       q_push, q_pop, q_full, q_empty;
  cmd_t       q_cmd, head_cmd;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full;

  // Slave address register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_id_r <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      slave_id_r <= cfg_slave_id;
    end
  end

  mrtu_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (q_full),
    .in_kind          (in_kind),
    .in_start_address (in_start_address),
    .in_register_count(in_register_count),
    .in_byte_count    (in_byte_count),
    .in_data_byte     (in_data_byte),
    .q_push           (q_push),
    .q_cmd            (q_cmd)
  );

  mrtu_cmd_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_cmd(q_cmd),
    .full    (q_full),
    .pop     (q_pop),
    .head_cmd(head_cmd),
    .empty   (q_empty)
  );

  mrtu_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .slave_id     (slave_id_r),
    .head_cmd     (head_cmd),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_tx_byte  (out_tx_byte),
    .out_frame_end(out_frame_end)
  );

`ifndef ASSERT_OFF
  // queue cannot be full and empty at once
  a_fifo_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_full && q_empty)) else $error("command queue full and empty");

  // retiring a command always leaves its last byte in the output register
  a_retire_out: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> !out_empty) else $error("command retired without output byte");

  // a queued command is visible to the sequencer next cycle
  a_push_seen: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |=> !q_empty) else $error("pushed command lost");

  // nothing reaches the byte side without a queued command
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_empty && q_empty) |=> out_empty) else $error("byte produced from nothing");
`endif

endmodule
